FILE: rtl/spm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spm_pkg
// Shared types and constants of the four channel stereo pan mixer.
// ----------------------------------------------------------------------------
package spm_pkg;

    // shared multiplier operand and product widths
    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = 21;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    localparam int ACC_W = 36;
    localparam int MIX_W = 20;

    localparam logic [15:0] Q15_ONE = 16'd32768;
    localparam logic [14:0] CV_FULL = 15'd20480;

    // floor(x / 5) = (x * DIV5_RECIP) >> DIV5_SHIFT for x < 2^22
    localparam logic [MUL_B_W-1:0] DIV5_RECIP = 21'd838861;
    localparam int DIV5_SHIFT = 22;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_M_SL,    // sample * level knob
        ST_M_CV,    // * level cv
        ST_DIV_CH,  // / (5 * 2^27) via reciprocal
        ST_DIV_PAN, // channel result out, pan cv * 16 / 5
        ST_PAN,     // pan clamp
        ST_M_L,     // ch * (1 - pan)
        ST_M_R,     // left add, ch * pan
        ST_ACC_R,   // right add
        ST_M_G,     // master knob * master cv
        ST_DIV_G,   // / 20480 via reciprocal
        ST_GAIN,    // master gain register
        ST_M_LO,    // acc low half * g
        ST_M_HI,    // acc high half * g
        ST_SUM,     // combine partial products
        ST_RND,     // round and saturate one side
        ST_OUT      // hand result to the output register
    } t_state;

endpackage

FILE: rtl/four_channel_stereo_pan_mixer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_channel_stereo_pan_mixer
// Per-channel gain and linear pan into left/right accumulators; on the
// frame's last channel the sums are scaled by the master gain and emitted.
//
//  channel  dir  tdata                                  tuser          tlast
//  s_axis   in   sample, lvl knob, lvl cv, pan knob,    channel_index  frame_end
//                pan cv, mst knob, mst cv (16b each)
//  m_axis   out  channel_out, mix_left, mix_right       tag, mix_valid -
//
// A new item is taken only in ST_IDLE; an item with tlast also runs the
// master gain states. All products go through one registered multiplier
// stepped by the sequencer. Synchronous active-low reset clears the control
// state and both accumulators. The result sits in an output register, so a
// new item is taken while it waits; a second result waits in ST_OUT.
// ----------------------------------------------------------------------------
module four_channel_stereo_pan_mixer (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // [15:0] sample, [31:16] level_knob, [47:32] level_cv, [63:48] pan_knob,
    // [79:64] pan_cv, [95:80] master_knob, [111:96] master_cv
    input  logic [111:0] i_s_axis_tdata,
    // [1:0] channel_index
    input  logic [1:0]   i_s_axis_tuser,
    input  logic         i_s_axis_tlast,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // [15:0] channel_out, [35:16] mix_left, [55:36] mix_right
    output logic [55:0]  o_m_axis_tdata,
    // [1:0] channel_tag, [2] mix_valid
    output logic [2:0]   o_m_axis_tuser
);
    import spm_pkg::*;

    t_state r_state, n_state;

    // captured item
    logic [1:0]         r_tag, n_tag;
    logic signed [15:0] r_smp, n_smp;
    logic [15:0]        r_lk, n_lk;
    logic [14:0]        r_lcv, n_lcv;
    logic [15:0]        r_pk, n_pk;
    logic signed [15:0] r_pcv, n_pcv;
    logic [15:0]        r_mk, n_mk;
    logic [14:0]        r_mcv, n_mcv;
    logic               r_last, n_last;

    // working registers
    logic                      r_neg, n_neg;
    logic signed [15:0]        r_ch, n_ch;
    logic [15:0]               r_pan, n_pan;
    logic [16:0]               r_g, n_g;
    logic                      r_side, n_side;
    logic signed [MUL_P_W-1:0] r_wide, n_wide;
    logic signed [ACC_W-1:0]   r_acc_l, n_acc_l;
    logic signed [ACC_W-1:0]   r_acc_r, n_acc_r;
    logic signed [MIX_W-1:0]   r_mix_l, n_mix_l;
    logic signed [MIX_W-1:0]   r_mix_r, n_mix_r;

    // output register
    logic                    r_m_valid, n_m_valid;
    logic [1:0]              r_m_tag, n_m_tag;
    logic signed [15:0]      r_m_ch, n_m_ch;
    logic signed [MIX_W-1:0] r_m_mix_l, n_m_mix_l;
    logic signed [MIX_W-1:0] r_m_mix_r, n_m_mix_r;
    logic                    r_m_mixv, n_m_mixv;

    // multiplier
    logic                      mul_en;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] w_prod;

    spm_mul u_mul (
        .i_clk (i_clk),
        .i_en  (mul_en),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (w_prod)
    );

    // input field clamps
    logic [15:0]        in_lk, in_pk, in_mk;
    logic signed [15:0] in_lcv_raw, in_mcv_raw;
    logic [14:0]        in_lcv, in_mcv;

    assign in_lk = (i_s_axis_tdata[31:16] > Q15_ONE) ? Q15_ONE : i_s_axis_tdata[31:16];
    assign in_pk = (i_s_axis_tdata[63:48] > Q15_ONE) ? Q15_ONE : i_s_axis_tdata[63:48];
    assign in_mk = (i_s_axis_tdata[95:80] > Q15_ONE) ? Q15_ONE : i_s_axis_tdata[95:80];
    assign in_lcv_raw = $signed(i_s_axis_tdata[47:32]);
    assign in_mcv_raw = $signed(i_s_axis_tdata[111:96]);
    assign in_lcv = in_lcv_raw[15] ? 15'd0 :
                    ((in_lcv_raw[14:0] > CV_FULL) ? CV_FULL : in_lcv_raw[14:0]);
    assign in_mcv = in_mcv_raw[15] ? 15'd0 :
                    ((in_mcv_raw[14:0] > CV_FULL) ? CV_FULL : in_mcv_raw[14:0]);

    // datapath helpers
    logic [MUL_P_W-1:0]        w_mag;
    logic [MUL_P_W-1:0]        w_mag_rnd;
    logic [19:0]               w_tch;
    logic [19:0]               w_q;
    logic signed [15:0]        w_ch;
    logic [15:0]               w_pcv_mag;
    logic [19:0]               w_xp;
    logic signed [21:0]        w_pan_sum;
    logic [15:0]               w_pan;
    logic [MUL_P_W-1:0]        w_u_sum;
    logic [19:0]               w_u;
    logic signed [ACC_W-1:0]   w_acc_sel;
    logic signed [MUL_P_W-1:0] w_rnd_sum;
    logic signed [22:0]        w_rnd;
    logic signed [MIX_W-1:0]   w_mix;
    logic signed [ACC_W-1:0]   w_prod2;

    assign w_mag     = w_prod[MUL_P_W-1] ? MUL_P_W'(-w_prod) : MUL_P_W'(w_prod);
    // magnitude + d/2 with d = 5 * 2^27, then the power-of-two part of d
    assign w_mag_rnd = w_mag + MUL_P_W'(5 * 2**26);
    assign w_tch     = w_mag_rnd[46:27];
    assign w_q       = w_prod[DIV5_SHIFT+19:DIV5_SHIFT];

    always_comb begin
        if (r_neg) begin
            w_ch = $signed(16'(16'd0 - w_q[15:0]));
        end else if (w_q > 20'd32767) begin
            w_ch = 16'sd32767;
        end else begin
            w_ch = $signed(w_q[15:0]);
        end
    end

    assign w_pcv_mag = r_pcv[15] ? 16'(16'd0 - r_pcv) : r_pcv;
    assign w_xp      = {w_pcv_mag, 4'b0000} + 20'd2;
    assign w_pan_sum = $signed({6'b0, r_pk}) +
                       (r_pcv[15] ? -$signed({2'b0, w_q}) : $signed({2'b0, w_q}));
    assign w_pan     = w_pan_sum[21] ? 16'd0 :
                       ((w_pan_sum > $signed({6'b0, Q15_ONE})) ? Q15_ONE : w_pan_sum[15:0]);

    assign w_u_sum   = w_prod + MUL_P_W'(10240);
    assign w_u       = w_u_sum[31:12];

    assign w_acc_sel = r_side ? r_acc_r : r_acc_l;
    assign w_prod2   = {w_prod[ACC_W-2:0], 1'b0};

    // ties away from zero: negative values round with one less bias
    assign w_rnd_sum = r_wide + MUL_P_W'(2**29) - MUL_P_W'(r_wide[MUL_P_W-1]);
    assign w_rnd     = w_rnd_sum[MUL_P_W-1:30];
    assign w_mix     = (w_rnd > 23'sd524287)  ? 20'sd524287 :
                       (w_rnd < -23'sd524288) ? -20'sd524288 : w_rnd[MIX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_m_valid <= 1'b0;
            r_acc_l   <= '0;
            r_acc_r   <= '0;
            r_side    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_m_valid <= n_m_valid;
            r_acc_l   <= n_acc_l;
            r_acc_r   <= n_acc_r;
            r_side    <= n_side;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag     <= n_tag;
        r_smp     <= n_smp;
        r_lk      <= n_lk;
        r_lcv     <= n_lcv;
        r_pk      <= n_pk;
        r_pcv     <= n_pcv;
        r_mk      <= n_mk;
        r_mcv     <= n_mcv;
        r_last    <= n_last;
        r_neg     <= n_neg;
        r_ch      <= n_ch;
        r_pan     <= n_pan;
        r_g       <= n_g;
        r_wide    <= n_wide;
        r_mix_l   <= n_mix_l;
        r_mix_r   <= n_mix_r;
        r_m_tag   <= n_m_tag;
        r_m_ch    <= n_m_ch;
        r_m_mix_l <= n_m_mix_l;
        r_m_mix_r <= n_m_mix_r;
        r_m_mixv  <= n_m_mixv;
    end

    always_comb begin
        n_state   = r_state;
        n_tag     = r_tag;
        n_smp     = r_smp;
        n_lk      = r_lk;
        n_lcv     = r_lcv;
        n_pk      = r_pk;
        n_pcv     = r_pcv;
        n_mk      = r_mk;
        n_mcv     = r_mcv;
        n_last    = r_last;
        n_neg     = r_neg;
        n_ch      = r_ch;
        n_pan     = r_pan;
        n_g       = r_g;
        n_side    = r_side;
        n_wide    = r_wide;
        n_acc_l   = r_acc_l;
        n_acc_r   = r_acc_r;
        n_mix_l   = r_mix_l;
        n_mix_r   = r_mix_r;
        n_m_tag   = r_m_tag;
        n_m_ch    = r_m_ch;
        n_m_mix_l = r_m_mix_l;
        n_m_mix_r = r_m_mix_r;
        n_m_mixv  = r_m_mixv;
        n_m_valid = (r_m_valid && i_m_axis_tready) ? 1'b0 : r_m_valid;
        mul_en    = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        o_s_axis_tready = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                o_s_axis_tready = 1'b1;
                if (i_s_axis_tvalid) begin
                    n_tag   = i_s_axis_tuser;
                    n_smp   = $signed(i_s_axis_tdata[15:0]);
                    n_lk    = in_lk;
                    n_lcv   = in_lcv;
                    n_pk    = in_pk;
                    n_pcv   = $signed(i_s_axis_tdata[79:64]);
                    n_mk    = in_mk;
                    n_mcv   = in_mcv;
                    n_last  = i_s_axis_tlast;
                    n_state = ST_M_SL;
                end
            end
            ST_M_SL: begin
                mul_en  = 1'b1;
                mul_a   = MUL_A_W'(r_smp);
                mul_b   = $signed({5'b0, r_lk});
                n_state = ST_M_CV;
            end
            ST_M_CV: begin
                mul_en  = 1'b1;
                mul_a   = w_prod[MUL_A_W-1:0];
                mul_b   = $signed({6'b0, r_lcv});
                n_state = ST_DIV_CH;
            end
            ST_DIV_CH: begin
                mul_en  = 1'b1;
                n_neg   = w_prod[MUL_P_W-1];
                mul_a   = $signed({12'b0, w_tch});
                mul_b   = $signed(DIV5_RECIP);
                n_state = ST_DIV_PAN;
            end
            ST_DIV_PAN: begin
                n_ch    = w_ch;
                mul_en  = 1'b1;
                mul_a   = $signed({12'b0, w_xp});
                mul_b   = $signed(DIV5_RECIP);
                n_state = ST_PAN;
            end
            ST_PAN: begin
                n_pan   = w_pan;
                n_state = ST_M_L;
            end
            ST_M_L: begin
                mul_en  = 1'b1;
                mul_a   = MUL_A_W'(r_ch);
                mul_b   = $signed({4'b0, 17'(17'd32768 - {1'b0, r_pan})});
                n_state = ST_M_R;
            end
            ST_M_R: begin
                n_acc_l = r_acc_l + w_prod2;
                mul_en  = 1'b1;
                mul_a   = MUL_A_W'(r_ch);
                mul_b   = $signed({5'b0, r_pan});
                n_state = ST_ACC_R;
            end
            ST_ACC_R: begin
                n_acc_r = r_acc_r + w_prod2;
                n_state = r_last ? ST_M_G : ST_OUT;
            end
            ST_M_G: begin
                mul_en  = 1'b1;
                mul_a   = $signed({16'b0, r_mk});
                mul_b   = $signed({6'b0, r_mcv});
                n_state = ST_DIV_G;
            end
            ST_DIV_G: begin
                mul_en  = 1'b1;
                mul_a   = $signed({12'b0, w_u});
                mul_b   = $signed(DIV5_RECIP);
                n_state = ST_GAIN;
            end
            ST_GAIN: begin
                n_g     = w_q[16:0];
                n_side  = 1'b0;
                n_state = ST_M_LO;
            end
            ST_M_LO: begin
                mul_en  = 1'b1;
                mul_a   = $signed({14'b0, w_acc_sel[17:0]});
                mul_b   = $signed({4'b0, r_g});
                n_state = ST_M_HI;
            end
            ST_M_HI: begin
                n_wide  = w_prod;
                mul_en  = 1'b1;
                // upper half carries the accumulator sign
                mul_a   = MUL_A_W'($signed(w_acc_sel[ACC_W-1:18]));
                mul_b   = $signed({4'b0, r_g});
                n_state = ST_SUM;
            end
            ST_SUM: begin
                n_wide  = $signed({w_prod[MUL_P_W-19:0], 18'b0}) + r_wide;
                n_state = ST_RND;
            end
            ST_RND: begin
                if (r_side) begin
                    n_mix_r = w_mix;
                    n_acc_l = '0;
                    n_acc_r = '0;
                    n_side  = 1'b0;
                    n_state = ST_OUT;
                end else begin
                    n_mix_l = w_mix;
                    n_side  = 1'b1;
                    n_state = ST_M_LO;
                end
            end
            ST_OUT: begin
                if (!r_m_valid || i_m_axis_tready) begin
                    n_m_valid = 1'b1;
                    n_m_tag   = r_tag;
                    n_m_ch    = r_ch;
                    n_m_mix_l = r_last ? r_mix_l : '0;
                    n_m_mix_r = r_last ? r_mix_r : '0;
                    n_m_mixv  = r_last;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = {r_m_mix_r, r_m_mix_l, r_m_ch};
    assign o_m_axis_tuser  = {r_m_mixv, r_m_tag};

endmodule

FILE: rtl/spm_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spm_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module spm_mul (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic signed [spm_pkg::MUL_A_W-1:0]  i_a,
    input  logic signed [spm_pkg::MUL_B_W-1:0]  i_b,
    output logic signed [spm_pkg::MUL_P_W-1:0]  o_p
);
    import spm_pkg::*;

    logic signed [MUL_P_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= i_a * i_b;
        end
    end

    assign o_p = r_p;

endmodule
